// ----- rtl/shc_pkg.sv -----
// Package for the strip hit cluster finder: field widths, the hit operation
// and cluster record types, the back-end state type and the saturating adder.
// No dependencies; every other file but shc_ram imports it.
`timescale 1ns / 1ps

package shc_pkg;

  localparam int STRIP_W    = 6;
  localparam int HIT_E_W    = 20;
  localparam int SIZE_W     = 7;
  localparam int SUM_W      = 24;
  localparam int MAX_STORED = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [HIT_E_W-1:0] THRESH_RESET = 20'd2000;
  localparam logic [SUM_W-1:0]   ENERGY_MAX   = 24'hFF_FFFF;

  // One classified hit as it travels from the front end to the back end.
  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    logic [HIT_E_W-1:0] energy;
    logic               keep;
    logic               last;
  } hit_op_t;

  // One cluster request on the result channel.
  typedef struct packed {
    logic [STRIP_W-1:0] first_strip;
    logic [SIZE_W-1:0]  cluster_size;
    logic [SUM_W-1:0]   cluster_energy;
    logic               last_cluster;
  } cluster_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC,
    BK_SCAN,
    BK_ADD,
    BK_FLUSH
  } back_state_t;

  // Adds two energies and clamps the sum to the largest 24-bit value.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? ENERGY_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ----- rtl/strip_hit_cluster_finder_top.sv -----
// Top level of the strip hit cluster finder: front end, hit queue and back end.
// Depends on shc_pkg, shc_front, shc_fifo, shc_back and shc_ram.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    strip_index, hit_energy, last_hit
//   out_      output     out_valid/out_ready  first_strip, cluster_size,
//                                             cluster_energy, last_cluster
//   cfg_      input      cfg_wr_en            cfg_wr_data (energy threshold)
//
// A hit below threshold is dropped as the back end takes it from the queue;
// a kept hit is read from the RAM, then written back with its energy added.
// At event end the scan visits each stored strip, adds each hit strip's energy
// after its registered read, then closes the scan and sends the final request.
// Reset is synchronous and active low; the hit marks clear at once, so no
// clearing pass is needed. The four-entry queue lets the input keep accepting,
// until full, while the back end scans or waits on a stalled result register.
`timescale 1ns / 1ps

module strip_hit_cluster_finder_top
  import shc_pkg::*;
#(
  parameter int NUM_STRIPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [HIT_E_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STRIP_W-1:0] in_strip_index,
  input  logic [HIT_E_W-1:0] in_hit_energy,
  input  logic               in_last_hit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STRIP_W-1:0] out_first_strip,
  output logic [SIZE_W-1:0]  out_cluster_size,
  output logic [SUM_W-1:0]   out_cluster_energy,
  output logic               out_last_cluster
);

  logic     q_push;
  hit_op_t  q_push_data;
  logic     q_full;
  logic     q_pop;
  hit_op_t  q_head;
  logic     q_valid;
  cluster_t out_data;

  shc_front #(
    .NUM_STRIPS (NUM_STRIPS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_strip_index (in_strip_index),
    .in_hit_energy  (in_hit_energy),
    .in_last_hit    (in_last_hit),
    .q_push         (q_push),
    .q_push_data    (q_push_data),
    .q_full         (q_full)
  );

  shc_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  shc_back #(
    .NUM_STRIPS (NUM_STRIPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_first_strip    = out_data.first_strip;
  assign out_cluster_size   = out_data.cluster_size;
  assign out_cluster_energy = out_data.cluster_energy;
  assign out_last_cluster   = out_data.last_cluster;

endmodule

// ----- rtl/shc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module shc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/shc_front.sv -----
// Front end of the cluster finder: holds the energy threshold register and
// classifies each incoming hit into a hit operation. Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_front
  import shc_pkg::*;
#(
  parameter int NUM_STRIPS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [HIT_E_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [STRIP_W-1:0] in_strip_index,
  input  logic [HIT_E_W-1:0] in_hit_energy,
  input  logic               in_last_hit,
  output logic               q_push,
  output hit_op_t            q_push_data,
  input  logic               q_full
);

  logic [HIT_E_W-1:0] thresh_r;
  logic [HIT_E_W-1:0] thresh_nxt;
  logic               in_range;

  // Threshold register; the user must write it only while the block is idle, which the block itself does not enforce.
  always_comb begin
    thresh_nxt = cfg_wr_en ? cfg_wr_data : thresh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else begin
      thresh_r <= thresh_nxt;
    end
  end

  // A hit counts when its strip exists and its energy is above threshold.
  assign in_range = 32'(in_strip_index) < NUM_STRIPS;

  assign in_ready    = !q_full;
  assign q_push      = in_valid && !q_full;
  assign q_push_data = '{strip:  in_strip_index,
                         energy: in_hit_energy,
                         keep:   in_range && (in_hit_energy > thresh_r),
                         last:   in_last_hit};

endmodule

// ----- rtl/shc_fifo.sv -----
// Short queue of hit operations between the front end and the back end.
// Depends on shc_pkg.
`timescale 1ns / 1ps

module shc_fifo
  import shc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  hit_op_t push_data,
  output logic    full,
  input  logic    pop,
  output hit_op_t head,
  output logic    head_valid
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  hit_op_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_pop;

  assign full       = count_r == CW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |=> !(count_r == CW'(QUEUE_DEPTH) && $past(push) && !$past(do_pop)
               && $past(count_r) == CW'(QUEUE_DEPTH)))
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_empty_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid && !push |=> count_r == '0)
    else $error("queue count changed without traffic");
`endif

endmodule

// ----- rtl/shc_back.sv -----
// Back end of the cluster finder: accumulates kept hits into the strip energy
// RAM, scans the strips at event end and drives the result register.
// Depends on shc_pkg and shc_ram.
`timescale 1ns / 1ps

module shc_back
  import shc_pkg::*;
#(
  parameter int NUM_STRIPS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  hit_op_t  q_head,
  input  logic     q_valid,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output cluster_t out_data
);

  // Only strips reachable through a 6-bit index are ever stored.
  localparam int NUM_STORED = (NUM_STRIPS < MAX_STORED) ? NUM_STRIPS : MAX_STORED;
  localparam int AW = $clog2(NUM_STORED);
  localparam int IW = $clog2(NUM_STORED + 1);

  back_state_t            state_r, state_nxt;
  hit_op_t                op_r, op_nxt;
  logic [NUM_STORED-1:0]  hit_r, hit_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   in_run_r, in_run_nxt;
  logic [STRIP_W-1:0]     run_start_r, run_start_nxt;
  logic [SIZE_W-1:0]      run_size_r, run_size_nxt;
  logic [SUM_W-1:0]       run_sum_r, run_sum_nxt;
  logic                   pend_vld_r, pend_vld_nxt;
  cluster_t               pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  cluster_t               out_r, out_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [SUM_W-1:0]       ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [SUM_W-1:0]       ram_rdata;

  logic                   out_free;
  logic                   push_c;
  cluster_t               push_data;
  logic                   scan_end;
  logic                   cur_hit;
  logic [AW-1:0]          op_addr;
  logic [AW-1:0]          idx_addr;

  shc_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_STORED)
  ) u_energy_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign op_addr   = op_r.strip[AW-1:0];
  assign idx_addr  = idx_r[AW-1:0];
  assign scan_end  = idx_r == IW'(NUM_STORED);
  assign cur_hit   = !scan_end && hit_r[idx_addr];
  assign ram_raddr = (state_r == BK_IDLE) ? q_head.strip[AW-1:0] : idx_addr;
  assign ram_waddr = op_addr;
  // A strip not yet hit in this event counts as zero energy.
  assign ram_wdata = sat_add(hit_r[op_addr] ? ram_rdata : '0,
                             {{(SUM_W-HIT_E_W){1'b0}}, op_r.energy});

  // Next state, accumulation, scan and result requests.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    hit_nxt       = hit_r;
    idx_nxt       = idx_r;
    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    run_size_nxt  = run_size_r;
    run_sum_nxt   = run_sum_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    push_c        = 1'b0;
    push_data     = pend_r;

    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop  = 1'b1;
          op_nxt = q_head;
          if (q_head.keep) begin
            state_nxt = BK_ACC;
          end else if (q_head.last) begin
            state_nxt  = BK_SCAN;
            idx_nxt    = '0;
            in_run_nxt = 1'b0;
          end
        end
      end
      BK_ACC: begin
        ram_we           = 1'b1;
        hit_nxt[op_addr] = 1'b1;
        if (op_r.last) begin
          state_nxt  = BK_SCAN;
          idx_nxt    = '0;
          in_run_nxt = 1'b0;
        end else begin
          state_nxt = BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (cur_hit) begin
          // Hit strip: its energy is read now and added next cycle.
          if (!in_run_r) begin
            run_start_nxt = STRIP_W'(idx_r);
            run_size_nxt  = '0;
            run_sum_nxt   = '0;
          end
          state_nxt = BK_ADD;
        end else if (in_run_r) begin
          // A run just ended; the held cluster goes out and this one is held.
          if (!pend_vld_r || out_free) begin
            push_c       = pend_vld_r;
            pend_nxt     = '{first_strip:    run_start_r,
                             cluster_size:   run_size_r,
                             cluster_energy: run_sum_r,
                             last_cluster:   1'b0};
            pend_vld_nxt = 1'b1;
            in_run_nxt   = 1'b0;
            if (scan_end) begin
              state_nxt = BK_FLUSH;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (scan_end) begin
          state_nxt = BK_FLUSH;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_ADD: begin
        run_sum_nxt  = sat_add(run_sum_r, ram_rdata);
        run_size_nxt = run_size_r + 1'b1;
        in_run_nxt   = 1'b1;
        idx_nxt      = idx_r + 1'b1;
        state_nxt    = BK_SCAN;
      end
      BK_FLUSH: begin
        // Final result of the event; the hit marks are cleared as it is sent.
        if (out_free) begin
          push_c = 1'b1;
          if (pend_vld_r) begin
            push_data              = pend_r;
            push_data.last_cluster = 1'b1;
          end else begin
            push_data = '{first_strip:    '0,
                          cluster_size:   '0,
                          cluster_energy: '0,
                          last_cluster:   1'b1};
          end
          pend_vld_nxt = 1'b0;
          hit_nxt      = '0;
          state_nxt    = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    if (push_c) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      hit_r       <= '0;
      idx_r       <= '0;
      in_run_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      idx_r       <= idx_nxt;
      in_run_r    <= in_run_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    run_start_r <= run_start_nxt;
    run_size_r  <= run_size_nxt;
    run_sum_r   <= run_sum_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_push_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_c |-> out_free)
    else $error("result register overwritten while still held");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_FLUSH && out_free |=> hit_r == '0 && !pend_vld_r)
    else $error("hit marks not cleared after event");
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cluster_size == '0 |-> out_r.last_cluster)
    else $error("empty cluster result without end-of-event flag");
  a_add_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_ADD |-> $past(state_r) == BK_SCAN)
    else $error("energy add step entered out of order");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for strip_hit_cluster_finder_top: drives hits of
// events, predicts the cluster requests and checks each one field by field.
// Depends on shc_pkg and the RTL of the cluster finder.
`timescale 1ns / 1ps

module tb_top;
  import shc_pkg::*;

  localparam int STRIPS         = 64;
  localparam int MAX_CLUSTERS   = 32;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PERCENT   = 9;

  // One hit to send, with an optional typed-in cluster for single-result events.
  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    logic [HIT_E_W-1:0] energy;
    logic               last;
    bit                 has_want;
    cluster_t           want;
  } hit_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [HIT_E_W-1:0] cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [STRIP_W-1:0] in_strip_index;
  logic [HIT_E_W-1:0] in_hit_energy;
  logic               in_last_hit;
  logic               out_valid;
  logic               out_ready;
  logic [STRIP_W-1:0] out_first_strip;
  logic [SIZE_W-1:0]  out_cluster_size;
  logic [SUM_W-1:0]   out_cluster_energy;
  logic               out_last_cluster;

  // Shadow copy of the threshold and the per-strip stores.
  logic [HIT_E_W-1:0] thresh_kev;
  logic [SUM_W-1:0]   strip_sum [STRIPS];
  logic               strip_marked [STRIPS];

  cluster_t awaited_clusters[$];
  cluster_t scan_clusters[$];
  hit_row_t directed_rows[$];

  int  error_count = 0;
  bit  quiet       = 1'b0;
  bit  hold_req    = 1'b0;

  strip_hit_cluster_finder_top #(
    .NUM_STRIPS(STRIPS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_strip_index    (in_strip_index),
    .in_hit_energy     (in_hit_energy),
    .in_last_hit       (in_last_hit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_first_strip   (out_first_strip),
    .out_cluster_size  (out_cluster_size),
    .out_cluster_energy(out_cluster_energy),
    .out_last_cluster  (out_last_cluster)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturating 24-bit energy sum.
  function automatic logic [SUM_W-1:0] clamp_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
  endfunction

  function automatic void clear_strips();
    for (int k = 0; k < STRIPS; k++) begin
      strip_sum[k]    = '0;
      strip_marked[k] = 1'b0;
    end
  endfunction

  function automatic cluster_t make_cluster(input int first, input int size,
                                            input int energy, input bit last);
    cluster_t c;
    c.first_strip    = STRIP_W'(first);
    c.cluster_size   = SIZE_W'(size);
    c.cluster_energy = SUM_W'(energy);
    c.last_cluster   = last;
    return c;
  endfunction

  function automatic hit_row_t make_row(input int strip, input int energy,
                                        input bit last);
    hit_row_t r;
    r.strip    = STRIP_W'(strip);
    r.energy   = HIT_E_W'(energy);
    r.last     = last;
    r.has_want = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  // Accumulates one hit; on the event's last hit, scans the strips in ascending
  // order into scan_clusters and clears the stores.
  function automatic void absorb_hit(input logic [STRIP_W-1:0] strip,
                                     input logic [HIT_E_W-1:0] energy,
                                     input logic last);
    int s;
    int n;
    int count;
    logic [SUM_W-1:0] sum;
    cluster_t c;
    if (int'(strip) < STRIPS && energy > thresh_kev) begin
      strip_sum[strip]    = clamp_sum(strip_sum[strip], {{(SUM_W-HIT_E_W){1'b0}}, energy});
      strip_marked[strip] = 1'b1;
    end
    if (!last) return;
    s     = 0;
    count = 0;
    while (s < STRIPS && count < MAX_CLUSTERS) begin
      if (!strip_marked[s]) begin
        s++;
        continue;
      end
      c.first_strip = STRIP_W'(s);
      sum = '0;
      n   = 0;
      while (s < STRIPS && strip_marked[s]) begin
        sum = clamp_sum(sum, strip_sum[s]);
        n++;
        s++;
      end
      c.cluster_size   = (n > 127) ? 7'd127 : SIZE_W'(n);
      c.cluster_energy = sum;
      c.last_cluster   = 1'b0;
      scan_clusters.push_back(c);
      count++;
    end
    // An event with no kept strip still reports one empty cluster.
    if (count == 0) scan_clusters.push_back(make_cluster(0, 0, 0, 1'b1));
    else scan_clusters[scan_clusters.size()-1].last_cluster = 1'b1;
    clear_strips();
  endfunction

  // Offers one hit request and records what it should produce once accepted.
  task automatic send_hit(input hit_row_t r);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_strip_index <= r.strip;
    in_hit_energy  <= r.energy;
    in_last_hit    <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_hit(r.strip, r.energy, r.last);
    if (r.has_want) awaited_clusters.push_back(r.want);
    else foreach (scan_clusters[k]) awaited_clusters.push_back(scan_clusters[k]);
    scan_clusters.delete();
    @(negedge clk);
  endtask

  // Energies around the threshold, at the maximum and across the full range.
  function automatic logic [HIT_E_W-1:0] pick_energy();
    logic [HIT_E_W-1:0] e;
    case ($urandom_range(0, 5))
      0: e = thresh_kev;
      1: e = (thresh_kev == '1) ? thresh_kev : thresh_kev + 1'b1;
      2: e = '1;
      3: e = HIT_E_W'($urandom_range(0, 20'hFFFFF));
      4: e = (thresh_kev == '0) ? '0 : HIT_E_W'($urandom_range(0, thresh_kev - 1));
      default: e = (thresh_kev > 20'hFFFFF - 4096) ? '1
                                                   : thresh_kev + HIT_E_W'($urandom_range(1, 4096));
    endcase
    return e;
  endfunction

  // Random events whose hits mostly fall in a narrow window, so neighbors join.
  task automatic run_events(input int budget);
    int len;
    int base;
    int window;
    int s;
    while (budget > 0) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      base   = $urandom_range(0, STRIPS - 1);
      window = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) s = $urandom_range(0, STRIPS - 1);
        else s = (base + $urandom_range(0, window - 1)) % STRIPS;
        send_hit(make_row(s, pick_energy(), k == len - 1));
      end
      budget -= len;
    end
  endtask

  // The threshold changes only once the block has drained.
  task automatic set_threshold(input logic [HIT_E_W-1:0] value);
    in_valid <= 1'b0;
    while (awaited_clusters.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    thresh_kev  = value;
  endtask

  function automatic void add_row(input int strip, input int energy, input bit last);
    directed_rows.push_back(make_row(strip, energy, last));
  endfunction

  function automatic void add_row_want(input int strip, input int energy,
                                       input int first, input int size, input int sum);
    hit_row_t r;
    r          = make_row(strip, energy, 1'b1);
    r.has_want = 1'b1;
    r.want     = make_cluster(first, size, sum, 1'b1);
    directed_rows.push_back(r);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Compare each cluster request with the oldest expectation.
  always @(posedge clk) begin
    cluster_t exp_c;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_clusters.size() == 0) begin
        $display("%0t: unexpected cluster first_strip %0d size %0d energy %0d last %0d",
                 $time, out_first_strip, out_cluster_size, out_cluster_energy,
                 out_last_cluster);
        error_count++;
      end else begin
        exp_c = awaited_clusters.pop_front();
        if (out_first_strip !== exp_c.first_strip) begin
          $display("%0t: first_strip expected %0d, got %0d",
                   $time, exp_c.first_strip, out_first_strip);
          error_count++;
        end
        if (out_cluster_size !== exp_c.cluster_size) begin
          $display("%0t: cluster_size expected %0d, got %0d",
                   $time, exp_c.cluster_size, out_cluster_size);
          error_count++;
        end
        if (out_cluster_energy !== exp_c.cluster_energy) begin
          $display("%0t: cluster_energy expected %0d, got %0d",
                   $time, exp_c.cluster_energy, out_cluster_energy);
          error_count++;
        end
        if (out_last_cluster !== exp_c.last_cluster) begin
          $display("%0t: last_cluster expected %0d, got %0d",
                   $time, exp_c.last_cluster, out_last_cluster);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request moving on either channel.
  initial begin
    int quiet_run;
    quiet_run = 0;
    while (quiet_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_run = 0;
      else quiet_run++;
    end
    $display("FAILURE");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    in_strip_index = '0;
    in_hit_energy  = '0;
    in_last_hit    = 1'b0;
    thresh_kev     = THRESH_RESET;
    clear_strips();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed events under the reset threshold.
    add_row_want(0, 0, 0, 0, 0);              // empty event
    add_row_want(63, 2001, 63, 1, 2001);      // top strip, just above threshold
    add_row_want(5, 2000, 0, 0, 0);           // energy equal to threshold is dropped
    add_row(20, 3000, 1'b0);
    add_row_want(21, 100, 20, 1, 3000);       // last hit below threshold still ends
    add_row(0, 20'hFFFFF, 1'b0);
    add_row(1, 20'hFFFFF, 1'b0);
    add_row(63, 5000, 1'b0);
    add_row(62, 2001, 1'b1);
    add_row(30, 2500, 1'b0);
    add_row(32, 2600, 1'b0);
    add_row(31, 2700, 1'b0);
    add_row(30, 2800, 1'b1);
    add_row(10, 4000, 1'b0);
    add_row(12, 4000, 1'b0);
    add_row(14, 4000, 1'b1);
    add_row(40, 1000, 1'b0);
    add_row_want(41, 0, 0, 0, 0);
    foreach (directed_rows[k]) send_hit(directed_rows[k]);

    // Receiver holds off while the most clusters arrive and hits queue up behind.
    hold_req = 1'b1;
    for (int k = 0; k < STRIPS; k += 2) send_hit(make_row(k, 3000 + k, k == STRIPS - 2));

    // One strip total saturates, then its cluster with a neighbor saturates too.
    for (int k = 0; k < 18; k++) send_hit(make_row((k == 17) ? 8 : 7, 20'hFFFFF, k == 17));

    // Threshold at zero: only energy zero is dropped.
    set_threshold('0);
    send_hit(make_row(3, 0, 1'b0));
    send_hit(make_row(4, 1, 1'b1));
    run_events(5);

    // Threshold at its maximum: nothing is ever kept.
    set_threshold('1);
    run_events(3);

    set_threshold(HIT_E_W'($urandom_range(0, 20'hFFFFF)));
    run_events(5);

    // A stretch with no idling on either side.
    quiet = 1'b1;
    set_threshold(HIT_E_W'($urandom_range(0, 8000)));
    run_events(12);
    quiet = 1'b0;

    set_threshold(THRESH_RESET);
    run_events(4);

    // Drain and report.
    in_valid <= 1'b0;
    while (awaited_clusters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
